// ----- sv/aabb_pkg.sv -----
package aabb_pkg;

   localparam int Q_W    = 24;
   localparam int SUM_W  = 34;
   localparam int PROD_W = 41;
   localparam int SCL_W  = 33;
   localparam int EDGE_W = 26;
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic signed [Q_W-1:0] Q_MAX = 24'sh7FFFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = -24'sh800000;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_SPAWN = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [2:0] REG_GRAVITY  = 3'd0;
   localparam logic [2:0] REG_MAX_FALL = 3'd1;
   localparam logic [2:0] REG_TSTEP    = 3'd2;
   localparam logic [2:0] REG_BODY_W   = 3'd3;
   localparam logic [2:0] REG_BODY_H   = 3'd4;
   localparam logic [2:0] REG_ACTIVE   = 3'd5;

   typedef struct packed {
      logic        [1:0]  op;
      logic        [5:0]  solid_index;
      logic signed [23:0] solid_left;
      logic signed [23:0] solid_top;
      logic        [22:0] solid_width;
      logic        [22:0] solid_height;
      logic signed [23:0] spawn_x;
      logic signed [23:0] spawn_y;
      logic signed [23:0] walk_speed;
      logic signed [23:0] new_vertical_speed;
      logic               override_vertical;
   } req_type;

   typedef struct packed {
      logic signed [23:0] body_x;
      logic signed [23:0] body_y;
      logic signed [23:0] speed_x;
      logic signed [23:0] speed_y;
      logic signed [23:0] before_x;
      logic signed [23:0] before_y;
      logic               on_ground;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] gravity;
      logic signed [23:0] max_fall;
      logic        [15:0] time_step;
      logic        [22:0] body_width;
      logic        [22:0] body_height;
      logic        [6:0]  active_solids;
   } cfg_type;

   // solid kept as its left, right, top and bottom edges; right and bottom are formed when the solid is written
   typedef struct packed {
      logic signed [Q_W-1:0]    sl;
      logic signed [EDGE_W-1:0] sr;
      logic signed [Q_W-1:0]    st;
      logic signed [EDGE_W-1:0] sb;
   } solid_type;

   function automatic logic signed [Q_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(Q_MAX);
      lo = SUM_W'(Q_MIN);
      if (v > hi) begin
         return Q_MAX;
      end else if (v < lo) begin
         return Q_MIN;
      end else begin
         return v[Q_W-1:0];
      end
   endfunction

endpackage

// ----- sv/aabb_body_collision_step.sv -----
// channel | ports              | direction | moves
// req     | req_valid/req_stall | in       | one command item (write solid, spawn, tick, no-op)
// rsp     | rsp_valid/rsp_stall | out      | one body state item per command
// csr     | csr_p*              | in/out   | APB register access, pready tied high
//
// Write, spawn and no-op items go from idle straight to the emit state.
// Tick: gravity (clamped at max_fall), then X and Y, each scaled by dt; each axis
// walks the solids and pushes out of each overlap. One multiplier scales speeds
// by dt; the store's single read port fetches one solid per cycle per axis between hits.
// Synchronous active-high reset clears the body state and loads the config defaults;
// the solid store is not cleared. req_stall is high while an item is in work;
// a result waiting under rsp_stall holds the block before it goes idle.
module aabb_body_collision_step #(
   parameter int MAX_SOLIDS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  aabb_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output aabb_pkg::rsp_type           rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [aabb_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [aabb_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [aabb_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import aabb_pkg::*;

   localparam int IDX_W = (MAX_SOLIDS > 1) ? $clog2(MAX_SOLIDS) : 1;
   localparam int CNT_W = $clog2(MAX_SOLIDS + 1);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MUL   = 9'b000000010,
      ST_RND   = 9'b000000100,
      ST_ADD   = 9'b000001000,
      ST_CLAMP = 9'b000010000,
      ST_FETCH = 9'b000100000,
      ST_WALK  = 9'b001000000,
      ST_PUSH  = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   typedef enum logic [2:0] {
      PH_GRAV = 3'b001,
      PH_X    = 3'b010,
      PH_Y    = 3'b100
   } phase_type;

   cfg_type cfg;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic signed [Q_W-1:0]    pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [Q_W-1:0]    vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [Q_W-1:0]    prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                     ground_ff, ground_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SCL_W-1:0]  scl_ff, scl_in;
   logic signed [EDGE_W-1:0] bl_ff, bl_in, br_ff, br_in, bt_ff, bt_in, bb_ff, bb_in;
   logic        [22:0]       half_hi_ff, half_hi_in;
   logic        [IDX_W-1:0]  idx_ff, idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic                     wr_en;
   solid_type                wr_data;
   logic                     rd_en;
   logic        [IDX_W-1:0]  rd_idx;
   solid_type                rd_data;

   logic        [21:0]       half_lo;
   logic        [CNT_W-1:0]  n_walk;
   logic                     last;
   logic                     hit;
   logic signed [Q_W-1:0]    mul_a;
   logic signed [Q_W-1:0]    add_a;
   logic signed [PROD_W-1:0] prod_c;
   logic signed [PROD_W-1:0] rnd_c;
   logic signed [SUM_W-1:0]  sum_c;
   logic signed [SUM_W-1:0]  push_c;
   state_type                done_state;

   aabb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   aabb_solid_store #(.DEPTH(MAX_SOLIDS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (IDX_W'(req_data.solid_index)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // out-of-range solid index is dropped
   assign wr_en = accept && (req_data.op == OP_WRITE) &&
                  (32'(req_data.solid_index) < MAX_SOLIDS);
   assign wr_data.sl = req_data.solid_left;
   assign wr_data.sr = $signed(req_data.solid_left) + $signed({3'b0, req_data.solid_width});
   assign wr_data.st = req_data.solid_top;
   assign wr_data.sb = $signed(req_data.solid_top) + $signed({3'b0, req_data.solid_height});

   assign half_lo = cfg.body_width[22:1];
   assign n_walk  = (32'(cfg.active_solids) > MAX_SOLIDS) ? CNT_W'(MAX_SOLIDS)
                                                          : CNT_W'(cfg.active_solids);
   assign last    = (CNT_W'(idx_ff) + CNT_W'(1)) == n_walk;

   // strict overlap on both axes
   assign hit = (bl_ff < $signed(rd_data.sr)) && (br_ff > $signed(rd_data.sl)) &&
                (bt_ff < $signed(rd_data.sb)) && (bb_ff > $signed(rd_data.st));

   always_comb begin
      case (phase_ff)
         PH_GRAV: mul_a = cfg.gravity;
         PH_X:    mul_a = vel_x_ff;
         default: mul_a = vel_y_ff;
      endcase
   end

   always_comb begin
      case (phase_ff)
         PH_X:    add_a = pos_x_ff;
         PH_Y:    add_a = pos_y_ff;
         default: add_a = vel_y_ff;
      endcase
   end

   assign prod_c = $signed(mul_a) * $signed({1'b0, cfg.time_step});
   // bias negatives so the shift truncates toward zero
   assign rnd_c  = prod_ff + $signed({{(PROD_W-8){1'b0}}, {8{prod_ff[PROD_W-1]}}});
   assign sum_c  = $signed(add_a) + $signed(scl_ff);

   always_comb begin
      if (phase_ff == PH_X) begin
         if (vel_x_ff[Q_W-1]) begin
            push_c = $signed(rd_data.sr) + $signed({12'b0, half_lo});
         end else begin
            push_c = $signed(rd_data.sl) - $signed({12'b0, half_lo});
         end
      end else begin
         push_c = $signed(rd_data.sb) + $signed({11'b0, cfg.body_height});
      end
   end

   assign done_state = (phase_ff == PH_Y) ? ST_EMIT : ST_MUL;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      vel_x_in     = vel_x_ff;
      vel_y_in     = vel_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      ground_in    = ground_ff;
      prod_in      = prod_ff;
      scl_in       = scl_ff;
      bl_in        = bl_ff;
      br_in        = br_ff;
      bt_in        = bt_ff;
      bb_in        = bb_ff;
      half_hi_in   = half_hi_ff;
      idx_in       = idx_ff;
      rd_en        = 1'b0;
      rd_idx       = idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EMIT;
               case (req_data.op)
                  OP_SPAWN: begin
                     pos_x_in  = req_data.spawn_x;
                     pos_y_in  = req_data.spawn_y;
                     prev_x_in = req_data.spawn_x;
                     prev_y_in = req_data.spawn_y;
                     vel_x_in  = '0;
                     vel_y_in  = '0;
                     ground_in = 1'b0;
                  end
                  OP_TICK: begin
                     vel_x_in = req_data.walk_speed;
                     if (req_data.override_vertical) begin
                        vel_y_in = req_data.new_vertical_speed;
                     end
                     prev_x_in = pos_x_ff;
                     prev_y_in = pos_y_ff;
                     phase_in  = PH_GRAV;
                     state_in  = ST_MUL;
                  end
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_MUL: begin
            prod_in    = prod_c;
            half_hi_in = cfg.body_width - {1'b0, half_lo};
            state_in   = ST_RND;
         end
         ST_RND: begin
            scl_in   = rnd_c[PROD_W-1:8];
            state_in = ST_ADD;
         end
         ST_ADD: begin
            idx_in = '0;
            case (phase_ff)
               PH_X: begin
                  pos_x_in = sat24(sum_c);
                  state_in = (n_walk == '0) ? done_state : ST_FETCH;
                  phase_in = (n_walk == '0) ? PH_Y : PH_X;
               end
               PH_Y: begin
                  pos_y_in  = sat24(sum_c);
                  ground_in = 1'b0;
                  state_in  = (n_walk == '0) ? ST_EMIT : ST_FETCH;
               end
               default: begin
                  vel_y_in = sat24(sum_c);
                  state_in = ST_CLAMP;
               end
            endcase
         end
         ST_CLAMP: begin
            if (vel_y_ff > cfg.max_fall) begin
               vel_y_in = cfg.max_fall;
            end
            phase_in = PH_X;
            state_in = ST_MUL;
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            rd_idx   = idx_ff;
            bl_in    = $signed(pos_x_ff) - $signed({4'b0, half_lo});
            br_in    = $signed(pos_x_ff) + $signed({3'b0, half_hi_ff});
            bt_in    = $signed(pos_y_ff) - $signed({3'b0, cfg.body_height});
            bb_in    = EDGE_W'(pos_y_ff);
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (hit) begin
               state_in = ST_PUSH;
            end else if (last) begin
               state_in = done_state;
               phase_in = PH_Y;
            end else begin
               rd_en  = 1'b1;
               rd_idx = idx_ff + IDX_W'(1);
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_PUSH: begin
            // zero speed leaves the position where it is
            if (phase_ff == PH_X) begin
               if (vel_x_ff != '0) begin
                  pos_x_in = sat24(push_c);
               end
               vel_x_in = '0;
            end else begin
               if (vel_y_ff > 0) begin
                  pos_y_in  = rd_data.st;
                  ground_in = 1'b1;
               end else if (vel_y_ff < 0) begin
                  pos_y_in = sat24(push_c);
               end
               vel_y_in = '0;
            end
            if (last) begin
               state_in = done_state;
               phase_in = PH_Y;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_FETCH;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.body_x    = pos_x_ff;
               rsp_data_in.body_y    = pos_y_ff;
               rsp_data_in.speed_x   = vel_x_ff;
               rsp_data_in.speed_y   = vel_y_ff;
               rsp_data_in.before_x  = prev_x_ff;
               rsp_data_in.before_y  = prev_y_ff;
               rsp_data_in.on_ground = ground_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_GRAV;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         ground_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         ground_ff    <= ground_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      scl_ff      <= scl_in;
      bl_ff       <= bl_in;
      br_ff       <= br_in;
      bt_ff       <= bt_in;
      bb_ff       <= bb_in;
      half_hi_ff  <= half_hi_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- sv/aabb_csr.sv -----
module aabb_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [aabb_pkg::CSR_AW-1:0] paddr,
   input  logic [aabb_pkg::CSR_DW-1:0] pwdata,
   output logic [aabb_pkg::CSR_DW-1:0] prdata,
   output logic                        pready,
   output aabb_pkg::cfg_type           cfg
);
   import aabb_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;

   assign reg_idx = paddr[4:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (reg_idx)
            REG_GRAVITY:  cfg_in.gravity       = pwdata[23:0];
            REG_MAX_FALL: cfg_in.max_fall      = pwdata[23:0];
            REG_TSTEP:    cfg_in.time_step     = pwdata[15:0];
            REG_BODY_W:   cfg_in.body_width    = pwdata[22:0];
            REG_BODY_H:   cfg_in.body_height   = pwdata[22:0];
            REG_ACTIVE:   cfg_in.active_solids = pwdata[6:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GRAVITY:  prdata = {8'd0, cfg_ff.gravity};
         REG_MAX_FALL: prdata = {8'd0, cfg_ff.max_fall};
         REG_TSTEP:    prdata = {16'd0, cfg_ff.time_step};
         REG_BODY_W:   prdata = {9'd0, cfg_ff.body_width};
         REG_BODY_H:   prdata = {9'd0, cfg_ff.body_height};
         REG_ACTIVE:   prdata = {25'd0, cfg_ff.active_solids};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity       <= '0;
         cfg_ff.max_fall      <= Q_MAX;
         cfg_ff.time_step     <= 16'd256;
         cfg_ff.body_width    <= 23'd256;
         cfg_ff.body_height   <= 23'd256;
         cfg_ff.active_solids <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/aabb_solid_store.sv -----
module aabb_solid_store #(
   parameter  int DEPTH = 64,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  aabb_pkg::solid_type wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_idx,
   output aabb_pkg::solid_type rd_data
);
   import aabb_pkg::*;

   solid_type mem [DEPTH];
   solid_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

endmodule

// ----- sv/aabb_chk.sv -----
module aabb_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input aabb_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input aabb_pkg::rsp_type rsp_data
);
   import aabb_pkg::*;

   // a result held back by the sink stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // one item at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while busy");

   // a new result only comes out of work in progress
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result item without an item in work");

   // spawn reports the spawn point, not grounded
   a_spawn: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.op == OP_SPAWN) && !rsp_valid |=>
      ##1 (rsp_valid && (rsp_data.body_x == $past(req_data.spawn_x, 2)) &&
           (rsp_data.body_y == $past(req_data.spawn_y, 2)) && !rsp_data.on_ground))
      else $error("spawn result mismatch");

endmodule

bind aabb_body_collision_step aabb_chk u_aabb_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import aabb_pkg::*;

   // Tracks the body and the solid table, and keeps the body states still owed by the block.
   class body_predictor;
      longint  sl[64], st[64], sw[64], sh[64];
      longint  px, py, vx, vy, bx, by;
      bit      grounded;
      longint  grav, fall, dt, bw, bh;
      int      active;
      rsp_type pending[$];
      int      mismatches, checked, landings;

      function new();
         px = 0; py = 0; vx = 0; vy = 0; bx = 0; by = 0;
         grounded = 1'b0;
         grav = 0; fall = 8388607; dt = 256; bw = 256; bh = 256; active = 0;
         mismatches = 0; checked = 0; landings = 0;
      endfunction

      task log_mismatch(string msg);
         mismatches++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      function longint q24(logic [23:0] v);
         return longint'($signed(v));
      endfunction

      function longint clip(longint v);
         if (v > 64'sd8388607) return 64'sd8388607;
         if (v < -64'sd8388608) return -64'sd8388608;
         return v;
      endfunction

      // speed times dt, Q8.8 scale dropped, rounded toward zero
      function longint dt_scaled(longint v);
         longint p;
         p = v * dt;
         if (p >= 0) return p >>> 8;
         return -((-p) >>> 8);
      endfunction

      function int solids_walked();
         return (active > 64) ? 64 : active;
      endfunction

      // strict interval overlap on both axes
      function bit overlapping(int i);
         longint bl, bt;
         bl = px - (bw >>> 1);
         bt = py - bh;
         return bl < sl[i] + sw[i] && bl + bw > sl[i] &&
                bt < st[i] + sh[i] && bt + bh > st[i];
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] v);
         case (idx)
            REG_GRAVITY:  grav = q24(v[23:0]);
            REG_MAX_FALL: fall = q24(v[23:0]);
            REG_TSTEP:    dt = longint'(v[15:0]);
            REG_BODY_W:   bw = longint'(v[22:0]);
            REG_BODY_H:   bh = longint'(v[22:0]);
            REG_ACTIVE:   active = int'(v[6:0]);
            default: ;
         endcase
      endfunction

      function void advance_x();
         int n;
         n = solids_walked();
         px = clip(px + dt_scaled(vx));
         for (int i = 0; i < n; i++) begin
            if (overlapping(i)) begin
               if (vx > 0) px = clip(sl[i] - (bw >>> 1));
               else if (vx < 0) px = clip(sl[i] + sw[i] + (bw >>> 1));
               vx = 0;
            end
         end
      endfunction

      function void advance_y();
         int n;
         n = solids_walked();
         py = clip(py + dt_scaled(vy));
         grounded = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (overlapping(i)) begin
               if (vy > 0) begin
                  py = st[i];
                  grounded = 1'b1;
               end else if (vy < 0) begin
                  py = clip(st[i] + sh[i] + bh);
               end
               vy = 0;
            end
         end
      endfunction

      function void take_command(req_type c);
         rsp_type e;
         int idx;
         case (c.op)
            OP_WRITE: begin
               idx = int'(c.solid_index);
               sl[idx] = q24(c.solid_left);
               st[idx] = q24(c.solid_top);
               sw[idx] = longint'(c.solid_width);
               sh[idx] = longint'(c.solid_height);
            end
            OP_SPAWN: begin
               px = q24(c.spawn_x);
               py = q24(c.spawn_y);
               bx = px;
               by = py;
               vx = 0;
               vy = 0;
               grounded = 1'b0;
            end
            OP_TICK: begin
               vx = q24(c.walk_speed);
               if (c.override_vertical) vy = q24(c.new_vertical_speed);
               bx = px;
               by = py;
               vy = clip(vy + dt_scaled(grav));
               if (vy > fall) vy = fall;
               advance_x();
               advance_y();
               if (grounded) landings++;
            end
            default: ;
         endcase
         e.body_x    = 24'(px);
         e.body_y    = 24'(py);
         e.speed_x   = 24'(vx);
         e.speed_y   = 24'(vy);
         e.before_x  = 24'(bx);
         e.before_y  = 24'(by);
         e.on_ground = grounded;
         pending.push_back(e);
      endfunction

      task compare_state(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            log_mismatch($sformatf("body state %h arrived with none owed", got));
         end else begin
            want = pending.pop_front();
            checked++;
            if (got.body_x !== want.body_x)
               log_mismatch($sformatf("body_x got %h want %h", got.body_x, want.body_x));
            if (got.body_y !== want.body_y)
               log_mismatch($sformatf("body_y got %h want %h", got.body_y, want.body_y));
            if (got.speed_x !== want.speed_x)
               log_mismatch($sformatf("speed_x got %h want %h", got.speed_x, want.speed_x));
            if (got.speed_y !== want.speed_y)
               log_mismatch($sformatf("speed_y got %h want %h", got.speed_y, want.speed_y));
            if (got.before_x !== want.before_x)
               log_mismatch($sformatf("before_x got %h want %h", got.before_x, want.before_x));
            if (got.before_y !== want.before_y)
               log_mismatch($sformatf("before_y got %h want %h", got.before_y, want.before_y));
            if (got.on_ground !== want.on_ground)
               log_mismatch($sformatf("on_ground got %b want %b", got.on_ground, want.on_ground));
         end
      endtask

      function int waiting();
         return pending.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_data;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   body_predictor book;
   bit  calm = 1'b0;
   int  items_sent = 0;
   int  settings_used = 0;

   aabb_body_collision_step uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   function automatic int pick(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int idle_cycles();
      return calm ? 0 : int'($urandom_range(0, 10));
   endfunction

   // every field random, op included; callers overwrite what they need
   function automatic req_type noise_item();
      req_type c;
      c.op                 = 2'($urandom);
      c.solid_index        = 6'($urandom);
      c.solid_left         = 24'($urandom);
      c.solid_top          = 24'($urandom);
      c.solid_width        = 23'($urandom);
      c.solid_height       = 23'($urandom);
      c.spawn_x            = 24'($urandom);
      c.spawn_y            = 24'($urandom);
      c.walk_speed         = 24'($urandom);
      c.new_vertical_speed = 24'($urandom);
      c.override_vertical  = 1'($urandom);
      return c;
   endfunction

   // valid stays up after the accept; the next negedge either replaces or drops it
   task automatic send_item(req_type c);
      int gap;
      gap = idle_cycles();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= c;
      do @(posedge clock); while (req_stall !== 1'b0);
      book.take_command(c);
      items_sent++;
   endtask

   task automatic send_write(int idx, int l, int t, int w, int h);
      req_type c;
      c = noise_item();
      c.op           = OP_WRITE;
      c.solid_index  = 6'(idx);
      c.solid_left   = 24'(l);
      c.solid_top    = 24'(t);
      c.solid_width  = 23'(w);
      c.solid_height = 23'(h);
      send_item(c);
   endtask

   task automatic send_spawn(int x, int y);
      req_type c;
      c = noise_item();
      c.op      = OP_SPAWN;
      c.spawn_x = 24'(x);
      c.spawn_y = 24'(y);
      send_item(c);
   endtask

   task automatic send_tick(int walk, bit ovr, int vert);
      req_type c;
      c = noise_item();
      c.op                 = OP_TICK;
      c.walk_speed         = 24'(walk);
      c.override_vertical  = ovr;
      c.new_vertical_speed = 24'(vert);
      send_item(c);
   endtask

   task automatic send_level_solid(int idx);
      send_write(idx, pick(-4096, 4096), pick(-3072, 512),
                 ($urandom_range(0, 7) == 0) ? 0 : pick(64, 2048), pick(0, 1024));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.waiting() != 0) @(posedge clock);
   endtask

   task automatic csr_cycle(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // write, mirror, then read back the low bits
   task automatic put_reg(logic [2:0] idx, int value);
      logic [31:0] mask, wval, rval;
      case (idx)
         REG_GRAVITY, REG_MAX_FALL: mask = 32'hFF_FFFF;
         REG_TSTEP:                 mask = 32'h00_FFFF;
         REG_BODY_W, REG_BODY_H:    mask = 32'h7F_FFFF;
         default:                   mask = 32'h00_007F;
      endcase
      wval = 32'(value) & mask;
      csr_cycle(1'b1, idx, wval, rval);
      book.set_register(idx, wval);
      csr_cycle(1'b0, idx, 32'h0, rval);
      if ((rval & mask) !== wval)
         book.log_mismatch($sformatf("register %0d reads %h, wrote %h", idx, rval, wval));
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         book.compare_state(rsp_data);
   end

   // result side back-pressure, drawn per result
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = idle_cycles();
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   initial begin
      #100_000_000;
      $display("timeout with %0d body states still owed", book.waiting());
      $display("FAIL aabb_body_collision_step");
      $finish;
   end

   initial begin
      req_type c;
      int      roll;
      book        = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings, no solids walked: saturation at the range edges
      settings_used++;
      c = noise_item();
      c.op = OP_NOP;
      send_item(c);
      send_tick(8388607, 1'b0, 0);
      send_tick(8388607, 1'b0, 0);
      send_tick(-8388608, 1'b1, -8388608);
      send_tick(0, 1'b1, 8388607);
      send_spawn(8388607, 8388607);
      send_tick(1, 1'b1, 1);
      send_spawn(-8388608, -8388608);
      send_tick(-1, 1'b1, -1);
      // floor, wall, zero-size block, ceiling, and one spanning the negative quadrant
      send_write(0, -4096, 0, 8192, 256);
      send_write(1, 512, -2048, 256, 2048);
      send_write(2, 0, -128, 0, 0);
      send_write(3, -4096, -2048, 8192, 256);
      send_write(4, -8388608, -8388608, 8388607, 8388607);

      drain_results();
      settings_used++;
      put_reg(REG_GRAVITY, 64);
      put_reg(REG_MAX_FALL, 1024);
      put_reg(REG_ACTIVE, 4);
      send_spawn(0, -10);
      send_tick(0, 1'b0, 0);          // lands on the floor
      send_tick(600, 1'b0, 0);        // pushed back flush against the wall
      send_tick(0, 1'b1, -1800);      // head hits the ceiling; wall edge only touches
      send_spawn(600, -10);           // inside the wall
      send_tick(0, 1'b0, 0);          // zero horizontal speed while overlapping
      send_tick(-700, 1'b0, 0);
      send_tick(0, 1'b1, 5000);       // clamped at the fall limit

      // fill the rest of the table so any count can be walked
      for (int i = 1; i < 64; i++) send_level_solid(i);

      for (int ph = 0; ph < 12; ph++) begin
         drain_results();
         calm = (ph % 4 == 1);
         settings_used++;
         case (ph % 6)
            0: begin
               put_reg(REG_GRAVITY, pick(8, 128));
               put_reg(REG_MAX_FALL, pick(256, 4096));
               put_reg(REG_TSTEP, pick(32, 768));
               put_reg(REG_BODY_W, pick(64, 1024));
               put_reg(REG_BODY_H, pick(64, 1024));
               put_reg(REG_ACTIVE, pick(1, 64));
            end
            1: begin
               put_reg(REG_GRAVITY, 8388607);
               put_reg(REG_MAX_FALL, 8388607);
               put_reg(REG_TSTEP, 65535);
               put_reg(REG_BODY_W, 8388607);
               put_reg(REG_BODY_H, 8388607);
               put_reg(REG_ACTIVE, 127);    // beyond the table, walks all 64
            end
            2: begin
               put_reg(REG_GRAVITY, -8388608);
               put_reg(REG_MAX_FALL, -8388608);
               put_reg(REG_TSTEP, 0);
               put_reg(REG_BODY_W, 0);
               put_reg(REG_BODY_H, 0);
               put_reg(REG_ACTIVE, 0);
            end
            3: begin
               put_reg(REG_GRAVITY, pick(16, 64));
               put_reg(REG_MAX_FALL, 2048);
               put_reg(REG_TSTEP, 256);
               put_reg(REG_BODY_W, 256);
               put_reg(REG_BODY_H, 512);
               put_reg(REG_ACTIVE, 64);
            end
            4: begin
               put_reg(REG_GRAVITY, int'($urandom));
               put_reg(REG_MAX_FALL, int'($urandom));
               put_reg(REG_TSTEP, int'($urandom));
               put_reg(REG_BODY_W, int'($urandom));
               put_reg(REG_BODY_H, int'($urandom));
               put_reg(REG_ACTIVE, int'($urandom));
            end
            default: begin
               put_reg(REG_GRAVITY, pick(-128, -8));
               put_reg(REG_MAX_FALL, pick(-4096, 4096));
               put_reg(REG_TSTEP, pick(64, 512));
               put_reg(REG_BODY_W, pick(64, 1024));
               put_reg(REG_BODY_H, pick(64, 1024));
               put_reg(REG_ACTIVE, pick(0, 64));
            end
         endcase
         send_write(0, -8192, 0, 16384, 512);
         for (int n = 0; n < 150; n++) begin
            if (n == 75) drain_results();    // hold off until the block has emptied
            roll = int'($urandom_range(0, 99));
            if (roll < 8) begin
               send_spawn(pick(-2048, 2048), pick(-1536, 0));
            end else if (roll < 13) begin
               send_level_solid(int'($urandom_range(0, 63)));
            end else if (roll < 85) begin
               send_tick(pick(-1024, 1024), $urandom_range(0, 5) == 0, pick(-3000, 600));
            end else begin
               send_item(noise_item());
            end
         end
      end

      drain_results();
      repeat (200) @(posedge clock);
      $display("Ran %0d command items under %0d register settings, range extremes included.",
               items_sent, settings_used);
      $display("Compared %0d body states, %0d landings on a solid top, %0d mismatches.",
               book.checked, book.landings, book.mismatches);
      if (book.mismatches == 0 && book.waiting() == 0) begin
         $display("PASS aabb_body_collision_step");
      end else begin
         $display("FAIL aabb_body_collision_step");
      end
      $finish;
   end

endmodule
